// File: sv/rlmu_pkg.sv
// ----------------------------------------------------------------------------
// rlmu_pkg: shared types and constants of the register logic/multiply unit
// Holds the payload structs of both channels and the decode codes of the
// AArch64 data-processing (register) word.
// ----------------------------------------------------------------------------
package rlmu_pkg;

    localparam int unsigned DataWidth = 64;
    localparam int unsigned HalfWidth = 32;
    localparam int unsigned RegIdxWidth = 5;

    // Instruction word field positions
    localparam int unsigned SfBit = 31;
    localparam int unsigned OpcLsb = 29;
    localparam int unsigned GroupBit = 28;
    localparam int unsigned OprLsb = 21;
    localparam int unsigned RmLsb = 16;
    localparam int unsigned SubBit = 15;
    localparam int unsigned Imm6Lsb = 10;
    localparam int unsigned RnLsb = 5;

    // Index of the zero register
    localparam logic [RegIdxWidth-1:0] REG_ZR = 5'd31;

    // Logical operation codes (opc)
    localparam logic [1:0] OPC_AND = 2'd0;
    localparam logic [1:0] OPC_ORR = 2'd1;
    localparam logic [1:0] OPC_EOR = 2'd2;
    localparam logic [1:0] OPC_ANDS = 2'd3;

    // Shift kinds (opr bits 2:1)
    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    typedef struct packed {
        logic [31:0] instruction_word;
        logic [63:0] first_source_value;
        logic [63:0] second_source_value;
        logic [63:0] accumulate_value;
    } op_t;

    typedef struct packed {
        logic [4:0]  dest_reg;
        logic [63:0] result_value;
        logic        write_enable;
        logic        flags_update;
        logic        flag_negative;
        logic        flag_zero;
        logic        flag_carry;
        logic        flag_overflow;
        logic        unsupported;
    } res_t;

endpackage

// File: sv/aarch64_register_logic_multiply_unit.sv
// ----------------------------------------------------------------------------
// aarch64_register_logic_multiply_unit: logical and multiply-accumulate ALU
// Executes one AArch64 data-processing (register) word per cycle, while res is
// not stalled, in a three-stage pipeline: shifted logical operations and MADD/MSUB.
// ----------------------------------------------------------------------------
// Usage
//   op channel (op_valid / op_stall / op): one instruction word with the
//   values of rn, rm and ra. A transfer happens at a rising edge with
//   op_valid high and op_stall low.
//   res channel (res_valid / res_stall / res): one result per instruction,
//   in order: rd, the value, write enable, the ANDS flags and the
//   unsupported mark for words outside the multiply group with opr bit 3 set.
// Pipeline and throughput
//   Three register stages (stage 1, stage 2, stage 3); res is driven by
//   the stage 3 register. One word per cycle is sustained while res is not
//   stalled; the 64-bit product is built from three 32x32 partial products
//   in stage 1, summed in stage 2 and accumulated in stage 3.
// Reset and stall
//   rst_n clears all stage valid bits; the pipeline comes up empty.
//   A stall on res holds the output register; earlier stages keep filling
//   empty slots, and op_stall rises only once every stage is occupied.
// ----------------------------------------------------------------------------
module aarch64_register_logic_multiply_unit
    import rlmu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic op_valid,
    output logic op_stall,
    input  op_t  op,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    // ------------------------------------------------------------------
    // Stage enables: a stage advances when it is empty or its successor
    // advances, so bubbles collapse under a downstream stall.
    // ------------------------------------------------------------------
    logic s1_en;
    logic s2_en;
    logic s3_en;

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;

    assign s3_en = !s3_valid_reg || !res_stall;
    assign s2_en = !s2_valid_reg || s3_en;
    assign s1_en = !s1_valid_reg || s2_en;
    assign op_stall = !s1_en;

    // ------------------------------------------------------------------
    // Stage 1: decode, operand masking, shifted operand, partial products
    // ------------------------------------------------------------------
    logic [31:0] iw;
    logic        wide;
    logic        is_mul;
    logic [3:0]  opr;
    logic [5:0]  imm6;
    logic [5:0]  amt;
    logic [63:0] wmask;
    logic [63:0] rn_m;
    logic [63:0] rm_m;
    logic [63:0] sext;
    logic [127:0] rot2;
    logic [63:0] sh_v;
    logic [63:0] op2;
    logic [63:0] acc;
    logic [63:0] pp_ll;
    logic [31:0] pp_lh;
    logic [31:0] pp_hl;

    always_comb
    begin
        iw     = op.instruction_word;
        wide   = iw[SfBit];
        is_mul = iw[GroupBit];
        opr    = iw[OprLsb +: 4];
        imm6   = iw[Imm6Lsb +: 6];
        wmask  = wide ? {DataWidth{1'b1}} : {{HalfWidth{1'b0}}, {HalfWidth{1'b1}}};
        rn_m   = op.first_source_value & wmask;
        rm_m   = op.second_source_value & wmask;
        // 32-bit forms use only the low five bits of the amount
        amt    = wide ? imm6 : {1'b0, imm6[4:0]};
        sext   = wide ? rm_m : {{HalfWidth{rm_m[31]}}, rm_m[31:0]};
        rot2   = wide ? {rm_m, rm_m} : {64'd0, rm_m[31:0], rm_m[31:0]};
        rot2   = rot2 >> amt;
        case (opr[2:1])
            SH_LSL:  sh_v = (rm_m << amt) & wmask;
            SH_LSR:  sh_v = rm_m >> amt;
            SH_ASR:  sh_v = $unsigned($signed(sext) >>> amt) & wmask;
            default: sh_v = rot2[63:0] & wmask;
        endcase
        op2 = opr[0] ? (~sh_v & wmask) : sh_v;
        // ra index of 31 reads as zero
        acc = (iw[Imm6Lsb +: RegIdxWidth] == REG_ZR) ? 64'd0
                                                     : (op.accumulate_value & wmask);
        pp_ll = rn_m[31:0] * rm_m[31:0];
        pp_lh = rn_m[31:0] * rm_m[63:32];
        pp_hl = rn_m[63:32] * rm_m[31:0];
    end

    logic        s1_wide_reg;
    logic        s1_mul_reg;
    logic        s1_uns_reg;
    logic        s1_sub_reg;
    logic [1:0]  s1_opc_reg;
    logic [4:0]  s1_rd_reg;
    logic [63:0] s1_a_reg;
    logic [63:0] s1_op2_reg;
    logic [63:0] s1_acc_reg;
    logic [63:0] s1_pp_ll_reg;
    logic [31:0] s1_pp_lh_reg;
    logic [31:0] s1_pp_hl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_en)
        begin
            s1_valid_reg <= op_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en && op_valid)
        begin
            s1_wide_reg  <= wide;
            s1_mul_reg   <= is_mul;
            s1_uns_reg   <= !is_mul && opr[3];
            s1_sub_reg   <= iw[SubBit];
            s1_opc_reg   <= iw[OpcLsb +: 2];
            s1_rd_reg    <= iw[RegIdxWidth-1:0];
            s1_a_reg     <= rn_m;
            s1_op2_reg   <= op2;
            s1_acc_reg   <= acc;
            s1_pp_ll_reg <= pp_ll;
            s1_pp_lh_reg <= pp_lh;
            s1_pp_hl_reg <= pp_hl;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: sum the partial products, combine the logical operands
    // ------------------------------------------------------------------
    logic [31:0] cross_sum;
    logic [63:0] prod;
    logic [63:0] lres;

    always_comb
    begin
        cross_sum = s1_pp_lh_reg + s1_pp_hl_reg;
        prod  = s1_pp_ll_reg + {cross_sum, 32'd0};
        case (s1_opc_reg)
            OPC_ORR: lres = s1_a_reg | s1_op2_reg;
            OPC_EOR: lres = s1_a_reg ^ s1_op2_reg;
            default: lres = s1_a_reg & s1_op2_reg;
        endcase
    end

    logic        s2_wide_reg;
    logic        s2_mul_reg;
    logic        s2_uns_reg;
    logic        s2_sub_reg;
    logic        s2_fu_reg;
    logic [4:0]  s2_rd_reg;
    logic [63:0] s2_acc_reg;
    logic [63:0] s2_prod_reg;
    logic [63:0] s2_lres_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_en && s1_valid_reg)
        begin
            s2_wide_reg <= s1_wide_reg;
            s2_mul_reg  <= s1_mul_reg;
            s2_uns_reg  <= s1_uns_reg;
            s2_sub_reg  <= s1_sub_reg;
            s2_fu_reg   <= !s1_mul_reg && !s1_uns_reg && (s1_opc_reg == OPC_ANDS);
            s2_rd_reg   <= s1_rd_reg;
            s2_acc_reg  <= s1_acc_reg;
            s2_prod_reg <= prod;
            s2_lres_reg <= lres;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: accumulate, mask to width, flags; output register
    // ------------------------------------------------------------------
    logic [63:0] s3_mask;
    logic [63:0] mac;
    res_t        s3_next;

    always_comb
    begin
        s3_mask = s2_wide_reg ? {DataWidth{1'b1}}
                              : {{HalfWidth{1'b0}}, {HalfWidth{1'b1}}};
        mac = (s2_sub_reg ? (s2_acc_reg - s2_prod_reg) : (s2_acc_reg + s2_prod_reg))
              & s3_mask;
        s3_next = '0;
        s3_next.dest_reg    = s2_rd_reg;
        s3_next.unsupported = s2_uns_reg;
        if (s2_mul_reg)
        begin
            s3_next.result_value = mac;
            s3_next.write_enable = 1'b1;
        end
        else if (!s2_uns_reg)
        begin
            s3_next.result_value = s2_lres_reg;
            s3_next.write_enable = 1'b1;
            if (s2_fu_reg)
            begin
                s3_next.flags_update  = 1'b1;
                s3_next.flag_negative = s2_wide_reg ? s2_lres_reg[63] : s2_lres_reg[31];
                s3_next.flag_zero     = (s2_lres_reg == 64'd0);
            end
        end
    end

    res_t s3_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_en)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_en && s2_valid_reg)
        begin
            s3_res_reg <= s3_next;
        end
    end

    assign res_valid = s3_valid_reg;
    assign res       = s3_res_reg;

`ifndef SYNTHESIS
    // An unsupported word never writes a register or the flags
    a_uns_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.unsupported |->
            !res.write_enable && !res.flags_update && (res.result_value == 64'd0))
        else $error("unsupported result carries data");

    // Flags are zero unless the result updates them
    a_flags_gated: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.flags_update |-> !res.flag_negative && !res.flag_zero)
        else $error("flags set without flags_update");

    // Carry and overflow are never produced
    a_cv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !res.flag_carry && !res.flag_overflow)
        else $error("carry or overflow set");

    // Input back-pressure only when every stage is full and the output stalls
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        op_stall |-> s1_valid_reg && s2_valid_reg && s3_valid_reg && res_stall)
        else $error("op_stall with a free stage");

    // A stalled pipeline that was full stays full
    a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
        op_stall |=> s1_valid_reg && s2_valid_reg && s3_valid_reg)
        else $error("item lost during stall");
`endif

endmodule
